// File: rtl/core/dbfs_pkg.sv
// Shared constants, codes and types of the double-buffered frame streamer.
package dbfs_pkg;

  // Frame geometry and field widths.
  localparam int COLUMNS = 32;
  localparam int ROWS    = 16;
  localparam int COL_W   = 5;
  localparam int ROW_W   = 4;
  localparam int BYTE_W  = 8;

  // One bank bit, then row, then column.
  localparam int ADDR_W  = 1 + ROW_W + COL_W;

  // Request codes carried on the mode field.
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_LINK   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_START_BYTE = 1'b0;
  localparam logic CFG_END_BYTE   = 1'b1;

  // Sender phases.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_XMIT,
    PH_END
  } phase_t;

  // Result of one request, as registered by the sequencer.
  typedef struct packed {
    logic              done;
    logic              tx_valid;
    logic              use_ram;
    logic [BYTE_W-1:0] byte_val;
    logic              link_free;
    logic              busy_res;
  } res_t;

  // Bank memory access issued by the sequencer.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: rtl/core/dbfs_bank_ram.sv
// Generic single-write, single-read synchronous RAM holding both pixel banks.
module dbfs_bank_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/dbfs_sequencer.sv
// Request sequencer: sender phase, scan position, bank flag and the clearing sweep.
module dbfs_sequencer import dbfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        mode,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  input  logic [BYTE_W-1:0] pixel_color,
  input  logic [BYTE_W-1:0] start_byte,
  input  logic [BYTE_W-1:0] end_byte,
  output logic              busy,
  output ram_req_t          ram_req,
  output res_t              res
);

  phase_t             phase;
  phase_t             phase_next;
  logic [COL_W-1:0]   scan_col;
  logic [COL_W-1:0]   scan_col_next;
  logic [ROW_W-1:0]   scan_row;
  logic [ROW_W-1:0]   scan_row_next;
  logic               shown_bank;
  logic               shown_bank_next;
  logic               clearing;
  logic [ADDR_W-1:0]  clear_cnt;
  res_t               res_next;
  logic               accept;
  logic               col_last;
  logic               row_last;
  logic               in_range;

  assign accept   = start && !clearing;
  assign busy     = clearing;
  assign col_last = (scan_col == COL_W'(COLUMNS - 1));
  assign row_last = (scan_row == ROW_W'(ROWS - 1));
  assign in_range = (32'(row) < ROWS) && (32'(col) < COLUMNS);

  // Next sender phase.
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_IDLE: begin
          if (mode == MODE_UPDATE) phase_next = PH_START;
        end
        PH_START: begin
          if (mode == MODE_LINK) phase_next = PH_XMIT;
        end
        PH_XMIT: begin
          if (mode == MODE_LINK && col_last && row_last) phase_next = PH_END;
        end
        PH_END: begin
          if (mode == MODE_LINK) phase_next = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Memory access, scan position and result of the request.
  always_comb begin
    scan_col_next   = scan_col;
    scan_row_next   = scan_row;
    shown_bank_next = shown_bank;
    ram_req.we      = 1'b0;
    ram_req.waddr   = {~shown_bank, row, col};
    ram_req.wdata   = pixel_color;
    ram_req.re      = 1'b0;
    ram_req.raddr   = {shown_bank, scan_row, scan_col};
    res_next.done      = accept;
    res_next.tx_valid  = 1'b0;
    res_next.use_ram   = 1'b0;
    res_next.byte_val  = '0;
    res_next.link_free = 1'b0;
    res_next.busy_res  = (phase_next != PH_IDLE);

    if (clearing) begin
      // Sweep zeros through both banks after reset.
      ram_req.we    = 1'b1;
      ram_req.waddr = clear_cnt;
      ram_req.wdata = '0;
    end else if (accept) begin
      unique case (mode)
        MODE_WRITE: begin
          ram_req.we = in_range;
        end
        MODE_UPDATE: begin
          if (phase == PH_IDLE) begin
            shown_bank_next   = ~shown_bank;
            res_next.tx_valid = 1'b1;
            res_next.byte_val = start_byte;
          end
        end
        MODE_LINK: begin
          if (phase == PH_START) begin
            scan_col_next     = '0;
            scan_row_next     = '0;
            ram_req.re        = 1'b1;
            ram_req.raddr     = {shown_bank, {ROW_W{1'b0}}, {COL_W{1'b0}}};
            res_next.tx_valid = 1'b1;
            res_next.use_ram  = 1'b1;
          end else if (phase == PH_XMIT) begin
            if (col_last) begin
              scan_col_next = '0;
              scan_row_next = row_last ? '0 : scan_row + 1'b1;
            end else begin
              scan_col_next = scan_col + 1'b1;
            end
            res_next.tx_valid = 1'b1;
            if (col_last && row_last) begin
              res_next.byte_val = end_byte;
            end else begin
              ram_req.re       = 1'b1;
              ram_req.raddr    = {shown_bank, scan_row_next, scan_col_next};
              res_next.use_ram = 1'b1;
            end
          end else if (phase == PH_END) begin
            res_next.link_free = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers and the registered result; of the result, only the done strobe is reset.
  always_ff @(posedge clk) begin
    res.tx_valid  <= res_next.tx_valid;
    res.use_ram   <= res_next.use_ram;
    res.byte_val  <= res_next.byte_val;
    res.link_free <= res_next.link_free;
    res.busy_res  <= res_next.busy_res;
    if (rst) begin
      phase      <= PH_IDLE;
      scan_col   <= '0;
      scan_row   <= '0;
      shown_bank <= 1'b0;
      clearing   <= 1'b1;
      clear_cnt  <= '0;
      res.done   <= 1'b0;
    end else begin
      phase      <= phase_next;
      scan_col   <= scan_col_next;
      scan_row   <= scan_row_next;
      shown_bank <= shown_bank_next;
      res.done   <= res_next.done;
      if (clearing) begin
        clear_cnt <= clear_cnt + 1'b1;
        if (clear_cnt == '1) clearing <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/double_buffered_frame_streamer.sv
// Top level of the double-buffered frame streamer: configuration, bank memory and result.
//
//   Channel   Handshake             Payload
//   request   start, busy           mode, row, col, pixel_color
//   result    done (one cycle)      tx_valid, tx_byte, bus_release, busy_res
//   config    cfg_we                cfg_index, cfg_data
//
// A request is taken on any cycle with start high and busy low, one per cycle;
// its result appears on the next cycle, from the registered result and the registered read of the bank RAM.
// After reset busy stays high while both banks are swept to zero;
// configuration writes are taken during the sweep.
// Results are shown for one cycle only and cannot be stalled by the receiver.
module double_buffered_frame_streamer import dbfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  input  logic [BYTE_W-1:0] pixel_color,
  output logic              done,
  output logic              tx_valid,
  output logic [BYTE_W-1:0] tx_byte,
  output logic              bus_release,
  output logic              busy_res,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BYTE_W-1:0] cfg_data
);

  logic [BYTE_W-1:0] frame_start_byte;
  logic [BYTE_W-1:0] frame_end_byte;
  logic [BYTE_W-1:0] rdata;
  ram_req_t          ram_req;
  res_t              res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_start_byte <= 8'd0;
      frame_end_byte   <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE: frame_start_byte <= cfg_data;
        CFG_END_BYTE:   frame_end_byte   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dbfs_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .row         (row),
    .col         (col),
    .pixel_color (pixel_color),
    .start_byte  (frame_start_byte),
    .end_byte    (frame_end_byte),
    .busy        (busy),
    .ram_req     (ram_req),
    .res         (res)
  );

  dbfs_bank_ram #(
    .ADDR_BITS (ADDR_W),
    .DATA_BITS (BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  // Pixel bytes come straight from the RAM read register, commands from the sequencer.
  assign done        = res.done;
  assign tx_valid    = res.tx_valid;
  assign tx_byte     = res.use_ram ? rdata : res.byte_val;
  assign bus_release = res.link_free;
  assign busy_res    = res.busy_res;

endmodule

// File: test/tb.sv
// Self-checking testbench for the double-buffered frame streamer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dbfs_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              bus_release;
    logic              busy_res;
  } link_result_t;

  // Tracks the streamer's banks and sender, and holds the link results still owed.
  class frame_tracker;
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
    phase_t            phase;
    logic [COL_W-1:0]  scan_col;
    logic [ROW_W-1:0]  scan_row;
    logic              shown;
    logic [BYTE_W-1:0] banks [2][ROWS*COLUMNS];
    link_result_t      owed_results [$];
    int unsigned       mismatches;

    function new();
      start_code = '0;
      end_code   = 8'd1;
      phase      = PH_IDLE;
      scan_col   = '0;
      scan_row   = '0;
      shown      = 1'b0;
      mismatches = 0;
      foreach (banks[b, a]) banks[b][a] = '0;
    endfunction

    function void set_register(logic idx, logic [BYTE_W-1:0] value);
      if (idx == CFG_START_BYTE) start_code = value;
      else end_code = value;
    endfunction

    function bit sender_idle();
      return phase == PH_IDLE;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function logic [BYTE_W-1:0] shown_pixel();
      return banks[shown][int'(scan_row) * COLUMNS + int'(scan_col)];
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void take_request(logic [1:0] m, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                               logic [BYTE_W-1:0] color);
      link_result_t res;
      res = '0;
      case (m)
        MODE_WRITE: begin
          banks[!shown][int'(r) * COLUMNS + int'(c)] = color;
        end
        MODE_UPDATE: begin
          if (phase == PH_IDLE) begin
            shown        = !shown;
            phase        = PH_START;
            res.tx_valid = 1'b1;
            res.tx_byte  = start_code;
          end
        end
        MODE_LINK: begin
          case (phase)
            PH_START: begin
              scan_row     = '0;
              scan_col     = '0;
              phase        = PH_XMIT;
              res.tx_valid = 1'b1;
              res.tx_byte  = shown_pixel();
            end
            PH_XMIT: begin
              if (int'(scan_col) == COLUMNS - 1) begin
                scan_col = '0;
                if (int'(scan_row) == ROWS - 1) begin
                  scan_row     = '0;
                  phase        = PH_END;
                  res.tx_valid = 1'b1;
                  res.tx_byte  = end_code;
                end else begin
                  scan_row++;
                end
              end else begin
                scan_col++;
              end
              if (phase == PH_XMIT) begin
                res.tx_valid = 1'b1;
                res.tx_byte  = shown_pixel();
              end
            end
            PH_END: begin
              res.bus_release = 1'b1;
              phase           = PH_IDLE;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      res.busy_res = (phase != PH_IDLE);
      owed_results.push_back(res);
    endfunction

    function void report(string what, link_result_t want, link_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: %s: expected valid=%0b byte=%02h release=%0b busy=%0b,",
                  " got valid=%0b byte=%02h release=%0b busy=%0b"},
                 $realtime, what, want.tx_valid, want.tx_byte, want.bus_release,
                 want.busy_res, got.tx_valid, got.tx_byte, got.bus_release, got.busy_res);
    endfunction

    // Compare one result from the block with the oldest one owed.
    function void check_result(link_result_t got);
      link_result_t want;
      if (owed_results.size() == 0) begin
        report("result with no request outstanding", '0, got);
        return;
      end
      want = owed_results.pop_front();
      if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
          got.bus_release !== want.bus_release || got.busy_res !== want.busy_res)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        mode = MODE_WRITE;
  logic [ROW_W-1:0]  row = '0;
  logic [COL_W-1:0]  col = '0;
  logic [BYTE_W-1:0] pixel_color = '0;
  logic              done;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              bus_release;
  logic              busy_res;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_START_BYTE;
  logic [BYTE_W-1:0] cfg_data = '0;

  frame_tracker sb = new();
  bit           gaps_on = 1'b1;
  int           stall_cycles = 0;

  double_buffered_frame_streamer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .row(row), .col(col), .pixel_color(pixel_color),
    .done(done), .tx_valid(tx_valid), .tx_byte(tx_byte),
    .bus_release(bus_release), .busy_res(busy_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Check every result on the cycle that it is shown.
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(link_result_t'({tx_valid, tx_byte, bus_release, busy_res}));
  end

  // Give up when no request has been taken for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Present one request after a random gap, when gaps are on, and hold it until the block takes it.
  task automatic issue_request(logic [1:0] m, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                               logic [BYTE_W-1:0] color);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= m;
    row         <= r;
    col         <= c;
    pixel_color <= color;
    @(posedge clk iff !busy);
    sb.take_request(m, r, c, color);
  endtask

  // Mostly link events while a frame is out, mostly writes and updates while idle.
  task automatic random_request();
    logic [1:0] m;
    int         pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) gaps_on = !gaps_on;
    if (sb.sender_idle())
      m = pick < 60 ? MODE_WRITE : pick < 85 ? MODE_UPDATE :
          pick < 95 ? MODE_LINK : MODE_UNUSED;
    else
      m = pick < 95 ? MODE_LINK : pick < 98 ? MODE_WRITE :
          pick < 99 ? MODE_UPDATE : MODE_UNUSED;
    issue_request(m, ROW_W'($urandom_range(0, ROWS - 1)),
                  COL_W'($urandom_range(0, COLUMNS - 1)), BYTE_W'($urandom));
  endtask

  // A fixed number of random requests, wherever the sender happens to be.
  task automatic run_requests(int requests);
    for (int i = 0; i < requests; i++) random_request();
  endtask

  // Keep going until the frame that is out has been finished.
  task automatic run_frame_out();
    while (!sb.sender_idle()) random_request();
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_registers(logic [BYTE_W-1:0] start_val, logic [BYTE_W-1:0] end_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_BYTE;
    cfg_data  <= start_val;
    @(posedge clk);
    cfg_index <= CFG_END_BYTE;
    cfg_data  <= end_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(CFG_START_BYTE, start_val);
    sb.set_register(CFG_END_BYTE, end_val);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Requests that do nothing while the sender is idle.
    issue_request(MODE_LINK, 4'd3, 5'd7, 8'h11);
    issue_request(MODE_UNUSED, 4'd15, 5'd31, 8'hFF);
    // Writes at the corners of the hidden bank and beside one, colours at both extremes.
    issue_request(MODE_WRITE, 4'd0, 5'd0, 8'hFF);
    issue_request(MODE_WRITE, 4'd15, 5'd31, 8'h5A);
    issue_request(MODE_WRITE, 4'd0, 5'd31, 8'h00);
    issue_request(MODE_WRITE, 4'd15, 5'd0, 8'hFF);
    issue_request(MODE_WRITE, 4'd0, 5'd1, 8'hA5);
    // Start a frame with the reset command bytes, then try to start another.
    issue_request(MODE_UPDATE, 4'd0, 5'd0, 8'h00);
    issue_request(MODE_UPDATE, 4'd9, 5'd2, 8'h33);
    issue_request(MODE_LINK, 4'd0, 5'd0, 8'h00);
    // A write during the frame must land in the hidden bank only.
    issue_request(MODE_WRITE, 4'd0, 5'd1, 8'h77);
    issue_request(MODE_LINK, 4'd0, 5'd0, 8'h00);
    issue_request(MODE_UNUSED, 4'd0, 5'd0, 8'h00);
    issue_request(MODE_LINK, 4'd0, 5'd0, 8'h00);

    // Change the command bytes part way through the frame, then finish it.
    run_requests(200);
    settle();
    write_registers(8'hFF, 8'h00);
    run_frame_out();
    // Short runs that start further frames under other settings.
    run_requests(60);
    settle();
    write_registers(8'h00, 8'hFF);
    run_requests(60);
    settle();
    write_registers(BYTE_W'($urandom), BYTE_W'($urandom));
    run_requests(60);
    settle();

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
